// ----- src/fault_window_prefetch_address_gen_assert.svh -----
// Assertion macros shared by the prefetch address generator modules.
`ifndef FAULT_WINDOW_PREFETCH_ADDRESS_GEN_ASSERT_SVH
`define FAULT_WINDOW_PREFETCH_ADDRESS_GEN_ASSERT_SVH

// Same-cycle implication: whenever cond holds, prop holds too.
`define FWPAG_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication: cond in one cycle, prop in the next.
`define FWPAG_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- src/fwpag_pkg.sv -----
// Types and constants of the fault-around prefetch address generator.
`timescale 1ns / 1ps
package fwpag_pkg;

    localparam int ADDR_W = 64;
    localparam int WIN_W  = 5;
    // burst length field, wide enough for twice the largest window
    localparam int CNT_W  = 7;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd4;

    typedef enum logic [1:0] {
        CMD_SKIP,   // disabled or empty window: handled clear
        CMD_SHORT,  // window under one page: handled, no page
        CMD_BURST   // one beat per whole page
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [ADDR_W-1:0]  start;
        logic [CNT_W-1:0]   count;
    } cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SUM,
        F_CLIP,
        F_SIZE
    } front_state_t;

endpackage

// ----- src/fwpag_front.sv -----
// Front end: takes a fault beat, clips the window to the region, sizes the burst.
`timescale 1ns / 1ps
module fwpag_front #(
    parameter int MAX_WINDOW = 16,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fwpag_pkg::WIN_W-1:0]    cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [fwpag_pkg::ADDR_W-1:0]   fault_address,
    input  logic [fwpag_pkg::ADDR_W-1:0]   region_start,
    input  logic [fwpag_pkg::ADDR_W-1:0]   region_end,
    output logic                           cmd_push,
    output fwpag_pkg::cmd_t                cmd,
    input  logic                           cmd_full
);
    import fwpag_pkg::*;

    localparam int NR_W = ADDR_W - PAGE_SHIFT;
    localparam int WS_W = WIN_W + 1;

    front_state_t       state_reg, state_next;
    logic [WIN_W-1:0]   window_reg;
    logic [WIN_W-1:0]   win_reg, win_next;
    logic [ADDR_W-1:0]  addr_reg, rstart_reg, rend_reg;
    logic [ADDR_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic               lo_ok_reg, lo_ok_next, hi_cy_reg, hi_cy_next;
    logic [ADDR_W-1:0]  start_reg, start_next, end_reg, end_next;
    logic               accept;
    logic [WS_W-1:0]    win_sat;
    logic [ADDR_W-1:0]  span;
    logic [ADDR_W:0]    lo_full, hi_full, diff;
    logic [NR_W-1:0]    nr;
    logic [CNT_W-1:0]   nr_cap;

    assign accept  = in_valid && in_ready;
    assign win_sat = ({1'b0, window_reg} > WS_W'(MAX_WINDOW)) ? WS_W'(MAX_WINDOW)
                                                              : {1'b0, window_reg};
    assign span    = ADDR_W'(win_reg) << PAGE_SHIFT;
    assign lo_full = {1'b0, addr_reg} - {1'b0, span};
    assign hi_full = {1'b0, addr_reg} + {1'b0, span};
    assign diff    = {1'b0, end_reg} - {1'b0, start_reg};
    assign nr      = diff[ADDR_W-1:PAGE_SHIFT];
    assign nr_cap  = (nr > NR_W'(2 * MAX_WINDOW)) ? CNT_W'(2 * MAX_WINDOW) : CNT_W'(nr);

    always_comb
    begin
        state_next = state_reg;
        win_next   = win_reg;
        lo_next    = lo_reg;
        lo_ok_next = lo_ok_reg;
        hi_next    = hi_reg;
        hi_cy_next = hi_cy_reg;
        start_next = start_reg;
        end_next   = end_reg;
        in_ready   = 1'b0;
        cmd_push   = 1'b0;
        cmd.start  = start_reg;
        cmd.count  = nr_cap;
        cmd.kind   = CMD_BURST;
        if (win_reg == '0 || diff[ADDR_W] || diff[ADDR_W-1:0] == '0)
        begin
            cmd.kind = CMD_SKIP;
        end
        else if (nr == '0)
        begin
            cmd.kind = CMD_SHORT;
        end
        case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    win_next   = win_sat[WIN_W-1:0];
                    state_next = F_SUM;
                end
            end
            F_SUM:
            begin
                // fault minus span (must stay above zero) and fault plus span
                lo_next    = lo_full[ADDR_W-1:0];
                lo_ok_next = !lo_full[ADDR_W] && lo_full[ADDR_W-1:0] != '0;
                hi_next    = hi_full[ADDR_W-1:0];
                hi_cy_next = hi_full[ADDR_W];
                state_next = F_CLIP;
            end
            F_CLIP:
            begin
                start_next = (lo_ok_reg && lo_reg >= rstart_reg) ? lo_reg : rstart_reg;
                end_next   = (hi_cy_reg || hi_reg > rend_reg) ? rend_reg : hi_reg;
                state_next = F_SIZE;
            end
            F_SIZE:
            begin
                if (!cmd_full)
                begin
                    cmd_push   = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            window_reg <= WINDOW_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg   <= fault_address;
            rstart_reg <= region_start;
            rend_reg   <= region_end;
        end
        win_reg   <= win_next;
        lo_reg    <= lo_next;
        lo_ok_reg <= lo_ok_next;
        hi_reg    <= hi_next;
        hi_cy_reg <= hi_cy_next;
        start_reg <= start_next;
        end_reg   <= end_next;
    end

endmodule

// ----- src/fwpag_cmd_fifo.sv -----
// Two-entry command queue between front and back end.
`timescale 1ns / 1ps
`include "fault_window_prefetch_address_gen_assert.svh"
module fwpag_cmd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fwpag_pkg::cmd_t  push_cmd,
    output logic             full,
    output logic             pop_valid,
    output fwpag_pkg::cmd_t  pop_cmd,
    input  logic             pop
);
    import fwpag_pkg::*;

    cmd_t        entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `FWPAG_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full || pop, "queue overflow")
    `FWPAG_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, pop_valid, "queue underflow")

endmodule

// ----- src/fwpag_back.sv -----
// Back end: turns queued commands into page beats through an output register.
`timescale 1ns / 1ps
`include "fault_window_prefetch_address_gen_assert.svh"
module fwpag_back #(
    parameter int PAGE_SHIFT = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  fwpag_pkg::cmd_t                cmd,
    output logic                           cmd_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [fwpag_pkg::ADDR_W-1:0]   page_address,
    output logic                           page_valid,
    output logic                           handled,
    output logic                           last
);
    import fwpag_pkg::*;

    localparam logic [ADDR_W-1:0] PAGE_BYTES = ADDR_W'(1) << PAGE_SHIFT;

    logic               active_reg, active_next;
    logic [ADDR_W-1:0]  page_reg, page_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic               ov_reg, ov_next;
    logic [ADDR_W-1:0]  oa_reg, oa_next;
    logic               opv_reg, opv_next, ohd_reg, ohd_next, olast_reg, olast_next;
    logic               out_free;

    assign out_free     = !ov_reg || out_ready;
    assign out_valid    = ov_reg;
    assign page_address = oa_reg;
    assign page_valid   = opv_reg;
    assign handled      = ohd_reg;
    assign last         = olast_reg;

    always_comb
    begin
        active_next = active_reg;
        page_next   = page_reg;
        left_next   = left_reg;
        ov_next     = ov_reg && !out_ready;
        oa_next     = oa_reg;
        opv_next    = opv_reg;
        ohd_next    = ohd_reg;
        olast_next  = olast_reg;
        cmd_pop     = 1'b0;
        if (out_free)
        begin
            if (active_reg)
            begin
                ov_next     = 1'b1;
                oa_next     = page_reg;
                opv_next    = 1'b1;
                ohd_next    = 1'b1;
                olast_next  = left_reg == CNT_W'(1);
                active_next = left_reg != CNT_W'(1);
                left_next   = left_reg - CNT_W'(1);
                page_next   = page_reg + PAGE_BYTES;
            end
            else if (cmd_valid)
            begin
                cmd_pop    = 1'b1;
                ov_next    = 1'b1;
                oa_next    = '0;
                opv_next   = 1'b0;
                ohd_next   = 1'b0;
                olast_next = 1'b1;
                case (cmd.kind)
                    CMD_SHORT:
                    begin
                        ohd_next = 1'b1;
                    end
                    CMD_BURST:
                    begin
                        // first page goes out at once, the rest from the counter
                        oa_next     = cmd.start;
                        opv_next    = 1'b1;
                        ohd_next    = 1'b1;
                        olast_next  = cmd.count == CNT_W'(1);
                        active_next = cmd.count != CNT_W'(1);
                        left_next   = cmd.count - CNT_W'(1);
                        page_next   = cmd.start + PAGE_BYTES;
                    end
                    default:
                    begin
                        ohd_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            left_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            left_reg   <= left_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg  <= page_next;
        oa_reg    <= oa_next;
        opv_reg   <= opv_next;
        ohd_reg   <= ohd_next;
        olast_reg <= olast_next;
    end

    `FWPAG_ASSERT_IMPLY(a_active_count, clk, rst_n, active_reg, left_reg != '0,
        "burst active with no pages left")
    `FWPAG_ASSERT_IMPLY(a_pop_idle, clk, rst_n, cmd_pop, !active_reg,
        "command taken during a burst")
    `FWPAG_ASSERT_IMPLY(a_nopage_last, clk, rst_n, ov_reg && !opv_reg, olast_reg,
        "beat without a page must end its fault")

endmodule

// ----- src/fault_window_prefetch_address_gen.sv -----
// Top level of the fault-around prefetch address generator.
//
//   channel   | dir | beat contents (low bit first)
//   ----------+-----+--------------------------------------------------------
//   s_axis    | in  | tdata: fault_address, region_start, region_end
//   m_axis    | out | tdata: page_address; tuser: page_valid, handled; tlast
//   cfg       | in  | cfg_wdata: pages per side of the fault, written on cfg_we
//
// A fault beat passes through the front-end states in order (accept, sum/difference
// with the span, clip to the region, size the burst) and is then queued.
// The back end drains a queued command at one page beat per cycle while
// m_axis_tready allows, giving N = 1..2*MAX_WINDOW beats per fault;
// the front end works on the next fault while the back end still emits.
// Reset clears the control state and loads the window register with 4.
// m_axis_tready low holds the output register; once the two-entry queue
// fills, the front end holds its command and s_axis_tready stays low.
`timescale 1ns / 1ps
module fault_window_prefetch_address_gen #(
    parameter int MAX_WINDOW = 16,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [fwpag_pkg::WIN_W-1:0]       cfg_wdata,     // pages per side
    // fault input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [3*fwpag_pkg::ADDR_W-1:0]    s_axis_tdata,  // fault_address, region_start, region_end
    // page output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [fwpag_pkg::ADDR_W-1:0]      m_axis_tdata,  // page_address
    output logic [1:0]                        m_axis_tuser,  // page_valid, handled
    output logic                              m_axis_tlast
);
    import fwpag_pkg::*;

    logic  push, full, pop, pop_valid;
    cmd_t  push_cmd, pop_cmd;

    fwpag_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .fault_address (s_axis_tdata[ADDR_W-1:0]),
        .region_start  (s_axis_tdata[2*ADDR_W-1:ADDR_W]),
        .region_end    (s_axis_tdata[3*ADDR_W-1:2*ADDR_W]),
        .cmd_push      (push),
        .cmd           (push_cmd),
        .cmd_full      (full)
    );

    // decouples window sizing from the page burst
    fwpag_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop       (pop)
    );

    fwpag_back #(
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (pop_valid),
        .cmd          (pop_cmd),
        .cmd_pop      (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .page_address (m_axis_tdata),
        .page_valid   (m_axis_tuser[0]),
        .handled      (m_axis_tuser[1]),
        .last         (m_axis_tlast)
    );

endmodule
